/* rtl/core/subpixel_disparity_refine_assert.svh */
// assertion macros shared by the subpixel disparity refine rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef SUBPIXEL_DISPARITY_REFINE_ASSERT_SVH
`define SUBPIXEL_DISPARITY_REFINE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked only while out of reset
`define SDR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define SDR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SDR_ASSERT(lbl, clk, rst_n, prop, msg)
`define SDR_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* rtl/core/sdr_pkg.sv */
// shared types for the subpixel disparity refine block
// no dependencies
package sdr_pkg;

  typedef enum logic {
    FIT_EQUIANGULAR = 1'b0,
    FIT_PARABOLA    = 1'b1
  } sdr_fit_e;

  // per-pixel control that travels beside the divider data
  typedef struct packed {
    logic valid;
    logic neg;
    logic clamped;
    logic degen;
  } sdr_tag_t;

endpackage

/* rtl/core/subpixel_disparity_refine.sv */
// subpixel disparity refine, top level: front-end fit, divider, output stage
// depends on sdr_pkg, sdr_div_pipe and subpixel_disparity_refine_assert.svh
//
// usage
//   slave stream takes one pixel per beat: three matching costs around the
//   best integer disparity and that disparity. master stream returns the
//   refined disparity (8 fraction bits by default) in tdata and the flags
//   offset_clamped and degenerate in tuser.
//   cfg_we_i / cfg_wdata_i write fit_mode (0 equiangular, 1 parabola);
//   write it only while no pixel is in flight.
// pipeline
//   a pixel goes from the accepting edge to the result beat through three
//   front-end stages, one divider stage per quotient bit (FRAC_BITS + 1)
//   and the output register. throughput is one pixel per cycle while
//   the receiver does not stall, set by the divider, which retires one
//   quotient bit per stage.
// reset and stall
//   reset empties the pipeline and sets fit_mode to equiangular.
//   while the receiver stalls a held result, the whole pipeline freezes and
//   s_axis_tready_o drops; nothing is lost or repeated.
`include "subpixel_disparity_refine_assert.svh"

module subpixel_disparity_refine
  import sdr_pkg::*;
#(
  parameter int COST_BITS = 16,
  parameter int FRAC_BITS = 8,
  parameter int DISP_BITS = 12,
  localparam int IN_W   = 3 * COST_BITS + DISP_BITS,
  localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W  = DISP_BITS + FRAC_BITS + 1,
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_wdata_i,     // fit_mode
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // cost_before, cost_center, cost_after, raw_disp
  input  logic [IN_TW-1:0]  s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [OUT_TW-1:0] m_axis_tdata_o,  // refined_disp
  output logic [1:0]        m_axis_tuser_o   // offset_clamped, degenerate
);

  localparam int MAG_W = COST_BITS + 2;

  sdr_fit_e fit_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q <= FIT_EQUIANGULAR;
    end else if (cfg_we_i) begin
      fit_mode_q <= sdr_fit_e'(cfg_wdata_i[0]);
    end
  end

  logic adv;
  logic out_valid_q;

  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // ---------------- stage 1: differences ----------------
  logic [COST_BITS-1:0] cost_before, cost_center, cost_after;
  logic [DISP_BITS-1:0] raw_disp;

  assign cost_before = s_axis_tdata_i[COST_BITS-1:0];
  assign cost_center = s_axis_tdata_i[2*COST_BITS-1:COST_BITS];
  assign cost_after  = s_axis_tdata_i[3*COST_BITS-1:2*COST_BITS];
  assign raw_disp    = s_axis_tdata_i[IN_W-1:3*COST_BITS];

  logic signed [COST_BITS+2:0] b_x, c_x, a_x;
  logic signed [COST_BITS+2:0] num_w, d1_w, d2_w;

  assign b_x   = signed'({3'b000, cost_before});
  assign c_x   = signed'({3'b000, cost_center});
  assign a_x   = signed'({3'b000, cost_after});
  assign num_w = (fit_mode_q == FIT_PARABOLA) ? (b_x - a_x) : (a_x - b_x);
  assign d1_w  = c_x - b_x;
  assign d2_w  = a_x - c_x;

  logic                        v1_q;
  sdr_fit_e                    mode1_q;
  logic signed [COST_BITS:0]   num1_q, d1_q, d2_q;
  logic signed [COST_BITS+2:0] s1_q;
  logic [DISP_BITS-1:0]        raw1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mode1_q <= fit_mode_q;
      num1_q  <= num_w[COST_BITS:0];
      d1_q    <= d1_w[COST_BITS:0];
      d2_q    <= d2_w[COST_BITS:0];
      s1_q    <= b_x + a_x - (c_x <<< 1);
      raw1_q  <= raw_disp;
    end
  end

  // ---------------- stage 2: denominator ----------------
  logic [COST_BITS:0]          m1, m2, amag;
  logic signed [COST_BITS+3:0] aden, den_w;

  assign m1    = d1_q[COST_BITS] ? (~d1_q + 1'b1) : d1_q;
  assign m2    = d2_q[COST_BITS] ? (~d2_q + 1'b1) : d2_q;
  assign amag  = (m1 > m2) ? m1 : m2;
  assign aden  = signed'({2'b00, amag, 1'b0});
  // sign of center minus before, zero counts as positive
  assign den_w = (mode1_q == FIT_PARABOLA) ? signed'({s1_q, 1'b0}) :
                 (d1_q[COST_BITS] ? -aden : aden);

  logic                        v2_q;
  logic signed [COST_BITS:0]   num2_q;
  logic signed [COST_BITS+3:0] den2_q;
  logic [DISP_BITS-1:0]        raw2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num2_q <= num1_q;
      den2_q <= den_w;
      raw2_q <= raw1_q;
    end
  end

  // ---------------- stage 3: magnitudes and flags ----------------
  logic [COST_BITS+3:0] mden_full;
  logic [COST_BITS:0]   mnum;
  logic [MAG_W-1:0]     mnum_x, mden;
  logic                 degen_w;
  sdr_tag_t             tag3_d, tag3_q;
  logic [MAG_W-1:0]     num3_q, den3_q;
  logic [DISP_BITS-1:0] raw3_q;

  assign mden_full = den2_q[COST_BITS+3] ? (~den2_q + 1'b1) : den2_q;
  assign mden      = mden_full[MAG_W-1:0];
  assign mnum      = num2_q[COST_BITS] ? (~num2_q + 1'b1) : num2_q;
  assign mnum_x    = {1'b0, mnum};
  assign degen_w   = (den2_q == '0);

  always_comb begin
    tag3_d.valid   = v2_q;
    tag3_d.neg     = num2_q[COST_BITS] ^ den2_q[COST_BITS+3];
    tag3_d.degen   = degen_w;
    // ratio beyond one; exactly one is not clamped
    tag3_d.clamped = !degen_w && (mnum_x > mden);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag3_q <= '0;
    end else if (adv) begin
      tag3_q <= tag3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num3_q <= mnum_x;
      den3_q <= mden;
      raw3_q <= raw2_q;
    end
  end

  // ---------------- divider ----------------
  sdr_tag_t             tag_dv;
  logic [FRAC_BITS:0]   quot_dv;
  logic [DISP_BITS-1:0] raw_dv;

  sdr_div_pipe #(
    .MAG_W     (MAG_W),
    .FRAC_BITS (FRAC_BITS),
    .DISP_BITS (DISP_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .tag_i  (tag3_q),
    .num_i  (num3_q),
    .den_i  (den3_q),
    .raw_i  (raw3_q),
    .tag_o  (tag_dv),
    .quot_o (quot_dv),
    .raw_o  (raw_dv)
  );

  // ---------------- output stage ----------------
  logic [FRAC_BITS:0] off_mag;
  logic [OUT_W-1:0]   off_x, off_s, raw_scaled, refined_d, refined_q;
  logic               clamped_q, degen_q;

  always_comb begin
    priority if (tag_dv.degen) begin
      off_mag = '0;
    end else if (tag_dv.clamped) begin
      off_mag = {1'b1, {FRAC_BITS{1'b0}}};
    end else begin
      off_mag = quot_dv;
    end
  end

  assign off_x      = OUT_W'(off_mag);
  assign off_s      = tag_dv.neg ? (~off_x + 1'b1) : off_x;
  assign raw_scaled = {raw_dv[DISP_BITS-1], raw_dv, {FRAC_BITS{1'b0}}};
  assign refined_d  = raw_scaled + off_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= tag_dv.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      refined_q <= refined_d;
      clamped_q <= tag_dv.clamped;
      degen_q   <= tag_dv.degen;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TW'(refined_q);
  assign m_axis_tuser_o  = {degen_q, clamped_q};

  // ---------------- assertions ----------------
  `SDR_ASSERT(a_flags_exclusive, clk_i, rst_ni,
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]),
    "clamped and degenerate both set")
  `SDR_ASSERT(a_flag_whole_offset, clk_i, rst_ni,
    (m_axis_tvalid_o && (m_axis_tuser_o[0] || m_axis_tuser_o[1])) |->
      (refined_q[FRAC_BITS-1:0] == '0),
    "flagged result carries a fraction")
  `SDR_ASSERT(a_stall_freezes_front, clk_i, rst_ni,
    !adv |=> ($stable(v1_q) && $stable(tag3_q)),
    "pipeline moved during a stall")
  // an edge seen in reset leaves the output and front-end valid bits cleared
  `SDR_ASSERT_ALWAYS(a_reset_empty, clk_i,
    !rst_ni |=> (!m_axis_tvalid_o && !v1_q && !v2_q && !tag3_q.valid),
    "pipeline not empty in reset")

endmodule

/* rtl/core/sdr_div_pipe.sv */
// pipelined restoring divider, one quotient bit per stage
// depends on sdr_pkg for the control tag
module sdr_div_pipe
  import sdr_pkg::*;
#(
  parameter int MAG_W     = 18,
  parameter int FRAC_BITS = 8,
  parameter int DISP_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  sdr_tag_t             tag_i,
  input  logic [MAG_W-1:0]     num_i,
  input  logic [MAG_W-1:0]     den_i,
  input  logic [DISP_BITS-1:0] raw_i,
  output sdr_tag_t             tag_o,
  output logic [FRAC_BITS:0]   quot_o,
  output logic [DISP_BITS-1:0] raw_o
);

  localparam int STAGES = FRAC_BITS + 1;

  sdr_tag_t             tag_q  [STAGES];
  logic [MAG_W-1:0]     rem_q  [STAGES];
  logic [MAG_W-1:0]     rem_d  [STAGES];
  logic [MAG_W-1:0]     den_q  [STAGES];
  logic [FRAC_BITS:0]   quot_q [STAGES];
  logic [FRAC_BITS:0]   quot_d [STAGES];
  logic [DISP_BITS-1:0] raw_q  [STAGES];

  always_comb begin
    logic [MAG_W:0]     trial;
    logic [MAG_W:0]     diff;
    logic [MAG_W-1:0]   dv;
    logic [FRAC_BITS:0] qv;
    logic               ge;
    for (int i = 0; i < STAGES; i++) begin
      // first stage tests the integer bit, later ones shift in a zero
      if (i == 0) begin
        trial = {1'b0, num_i};
        dv    = den_i;
        qv    = '0;
      end else begin
        trial = {rem_q[i-1], 1'b0};
        dv    = den_q[i-1];
        qv    = quot_q[i-1];
      end
      ge        = (trial >= {1'b0, dv});
      diff      = ge ? (trial - {1'b0, dv}) : trial;
      rem_d[i]  = diff[MAG_W-1:0];
      quot_d[i] = {qv[FRAC_BITS-1:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STAGES; i++) begin
        tag_q[i] <= '0;
      end
    end else if (en_i) begin
      tag_q[0] <= tag_i;
      for (int i = 1; i < STAGES; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0] <= den_i;
      raw_q[0] <= raw_i;
      for (int i = 1; i < STAGES; i++) begin
        den_q[i] <= den_q[i-1];
        raw_q[i] <= raw_q[i-1];
      end
      for (int i = 0; i < STAGES; i++) begin
        rem_q[i]  <= rem_d[i];
        quot_q[i] <= quot_d[i];
      end
    end
  end

  assign tag_o  = tag_q[STAGES-1];
  assign quot_o = quot_q[STAGES-1];
  assign raw_o  = raw_q[STAGES-1];

endmodule
